/* src/clx_pkg.sv */
// ----------------------------------------------------------------------------
// clx_pkg: shared types and constants of the character stream lexer
// Item structs, token kinds, error codes, lexer modes and character classes.
// ----------------------------------------------------------------------------
`default_nettype none

package clx_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } char_item_t;

  typedef struct packed {
    logic [4:0]  tok_kind;
    logic [15:0] token_start;
    logic [11:0] token_length;
    logic [2:0]  error_code;
    logic [7:0]  bad_char;
    logic        last_result;
  } token_item_t;

  // Up to three results come out of one input item.
  typedef struct packed {
    logic [1:0]            count;
    token_item_t [2:0]     slot;
  } batch_t;

  typedef enum logic [6:0] {
    MODE_IDLE = 7'b0000001,
    MODE_EQ   = 7'b0000010,
    MODE_NAME = 7'b0000100,
    MODE_NUM  = 7'b0001000,
    MODE_STR  = 7'b0010000,
    MODE_CHR  = 7'b0100000,
    MODE_SKIP = 7'b1000000
  } mode_t;

  typedef enum logic [1:0] {
    KW_NONE = 2'd0,
    KW_TO   = 2'd1,
    KW_FROM = 2'd2,
    KW_IF   = 2'd3
  } kw_t;

  localparam logic [4:0] KIND_EQ     = 5'd12;
  localparam logic [4:0] KIND_EE     = 5'd13;
  localparam logic [4:0] KIND_STR    = 5'd14;
  localparam logic [4:0] KIND_CHR    = 5'd15;
  localparam logic [4:0] KIND_TO     = 5'd16;
  localparam logic [4:0] KIND_FROM   = 5'd17;
  localparam logic [4:0] KIND_IF     = 5'd18;
  localparam logic [4:0] KIND_NAME   = 5'd19;
  localparam logic [4:0] KIND_NUMBER = 5'd20;
  localparam logic [4:0] KIND_END    = 5'd21;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
  localparam logic [2:0] ERR_OPEN_STR = 3'd2;
  localparam logic [2:0] ERR_OPEN_CHR = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG = 3'd4;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_USCORE = 8'h5f;

  // Punctuation; a hit's index is its token kind.
  localparam logic [7:0] PUNCT_CHARS [12] = '{
    8'h28, 8'h29, 8'h7b, 8'h7d, 8'h2f, 8'h2c,
    8'h25, 8'h3e, 8'h3c, 8'h2a, 8'h2b, 8'h2d
  };

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (c == PUNCT_CHARS[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [4:0] punct_kind(logic [7:0] c);
    logic [4:0] k;
    k = 5'd0;
    for (int i = 0; i < 12; i++) begin
      if (c == PUNCT_CHARS[i]) k = 5'(i);
    end
    return k;
  endfunction

  function automatic logic [2:0] kw_len(kw_t k);
    logic [2:0] n;
    unique case (k)
      KW_TO:   n = 3'd2;
      KW_FROM: n = 3'd4;
      KW_IF:   n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Expected keyword character at a given position.
  function automatic logic [7:0] kw_char(kw_t k, logic [1:0] idx);
    logic [31:0] word;
    unique case (k)
      KW_TO:   word = {8'h00, 8'h00, 8'h6f, 8'h74};
      KW_FROM: word = {8'h6d, 8'h6f, 8'h72, 8'h66};
      KW_IF:   word = {8'h00, 8'h00, 8'h66, 8'h69};
      default: word = 32'h0;
    endcase
    return word[idx*8 +: 8];
  endfunction

  function automatic logic [4:0] kw_kind(kw_t k);
    logic [4:0] r;
    unique case (k)
      KW_TO:   r = KIND_TO;
      KW_FROM: r = KIND_FROM;
      KW_IF:   r = KIND_IF;
      default: r = KIND_NAME;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/clx_core.sv */
// ----------------------------------------------------------------------------
// clx_core: lexer state and per-byte decode
// Turns the registered byte and the lexer state into a batch of results.
// ----------------------------------------------------------------------------
`default_nettype none

module clx_core #(
  parameter int MAX_TOKEN_LEN    = 4095,
  parameter int SOURCE_ADDR_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire clx_pkg::char_item_t char_item,
  output clx_pkg::batch_t          batch
);
  import clx_pkg::*;

  localparam int RW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int AW = SOURCE_ADDR_BITS;
  localparam logic [RW-1:0] RUN_MAX = RW'(MAX_TOKEN_LEN);

  mode_t          mode, mode_next;
  kw_t            kw, kw_next;
  logic [AW-1:0]  start_off, start_off_next;
  logic [RW-1:0]  run, run_next;
  logic [AW-1:0]  pos, pos_next;

  function automatic token_item_t make_item(logic [4:0] kind, logic [AW-1:0] start,
                                            logic [RW-1:0] len, logic [2:0] err,
                                            logic [7:0] bad);
    logic [31:0] s32;
    logic [31:0] l32;
    token_item_t t;
    s32 = 32'(start);
    l32 = 32'(len);
    t.tok_kind     = kind;
    t.token_start  = s32[15:0];
    t.token_length = l32[11:0];
    t.error_code   = err;
    t.bad_char     = bad;
    t.last_result  = 1'b0;
    return t;
  endfunction

  function automatic token_item_t word_item(mode_t m, kw_t k, logic [AW-1:0] s,
                                            logic [RW-1:0] l);
    logic [4:0] kind;
    if (m == MODE_NUM) kind = KIND_NUMBER;
    else if (k != KW_NONE && l == RW'(kw_len(k))) kind = kw_kind(k);
    else kind = KIND_NAME;
    return make_item(kind, s, l, ERR_NONE, 8'h00);
  endfunction

  always_comb begin
    logic [7:0]    c;
    logic          again;
    logic          cont;
    logic [1:0]    n;
    logic [AW-1:0] p_inc;

    c     = char_item.char_code;
    p_inc = pos + AW'(1);
    again = 1'b0;
    cont  = 1'b0;
    n     = 2'd0;
    batch = '0;
    mode_next      = mode;
    kw_next        = kw;
    start_off_next = start_off;
    run_next       = run;

    unique case (mode)
      MODE_IDLE: again = 1'b1;
      MODE_EQ: begin
        mode_next = MODE_IDLE;
        if (c == CH_EQ) begin
          batch.slot[n] = make_item(KIND_EE, start_off, RW'(2), ERR_NONE, 8'h00);
          n = n + 2'd1;
        end else begin
          batch.slot[n] = make_item(KIND_EQ, start_off, RW'(1), ERR_NONE, 8'h00);
          n = n + 2'd1;
          again = 1'b1;
        end
      end
      MODE_NAME, MODE_NUM: begin
        cont = is_alpha(c) || is_digit(c) ||
               ((mode == MODE_NAME) ? (c == CH_USCORE) : (c == CH_DOT));
        if (cont) begin
          // Drop the keyword candidate on the first mismatch.
          if (mode == MODE_NAME && kw != KW_NONE) begin
            if (!(run < RW'(kw_len(kw)) && kw_char(kw, run[1:0]) == c)) kw_next = KW_NONE;
          end
          if (run >= RUN_MAX) begin
            batch.slot[n] = make_item(KIND_END, start_off, '0, ERR_TOO_LONG, 8'h00);
            n = n + 2'd1;
            mode_next = MODE_SKIP;
          end else begin
            run_next = run + RW'(1);
          end
        end else begin
          batch.slot[n] = word_item(mode, kw, start_off, run);
          n = n + 2'd1;
          mode_next = MODE_IDLE;
          again = 1'b1;
        end
      end
      MODE_STR, MODE_CHR: begin
        if (c == ((mode == MODE_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
          batch.slot[n] = make_item((mode == MODE_STR) ? KIND_STR : KIND_CHR,
                                    start_off, run, ERR_NONE, 8'h00);
          n = n + 2'd1;
          mode_next = MODE_IDLE;
        end else if (run >= RUN_MAX) begin
          batch.slot[n] = make_item(KIND_END, start_off, '0, ERR_TOO_LONG, 8'h00);
          n = n + 2'd1;
          mode_next = MODE_SKIP;
        end else begin
          run_next = run + RW'(1);
        end
      end
      default: ;
    endcase

    // Start a new token on this byte.
    if (again && !is_space(c)) begin
      if (is_punct(c)) begin
        batch.slot[n] = make_item(punct_kind(c), pos, RW'(1), ERR_NONE, 8'h00);
        n = n + 2'd1;
      end else begin
        start_off_next = pos;
        run_next       = '0;
        kw_next        = KW_NONE;
        if (c == CH_EQ) begin
          mode_next = MODE_EQ;
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
          start_off_next = p_inc;
          mode_next = (c == CH_DQUOTE) ? MODE_STR : MODE_CHR;
        end else if (is_alpha(c)) begin
          run_next  = RW'(1);
          kw_next   = (c == 8'h74) ? KW_TO : (c == 8'h66) ? KW_FROM :
                      (c == 8'h69) ? KW_IF : KW_NONE;
          mode_next = MODE_NAME;
        end else if (is_digit(c)) begin
          run_next  = RW'(1);
          mode_next = MODE_NUM;
        end else begin
          batch.slot[n] = make_item(KIND_END, pos, '0, ERR_UNKNOWN, c);
          n = n + 2'd1;
          mode_next = MODE_SKIP;
        end
      end
    end

    // Close the source: flush what is pending, then rearm.
    pos_next = p_inc;
    if (char_item.end_of_source) begin
      priority case (mode_next)
        MODE_NAME, MODE_NUM: begin
          batch.slot[n] = word_item(mode_next, kw_next, start_off_next, run_next);
          n = n + 2'd1;
        end
        MODE_EQ: begin
          batch.slot[n] = make_item(KIND_EQ, start_off_next, RW'(1), ERR_NONE, 8'h00);
          n = n + 2'd1;
        end
        MODE_STR: begin
          batch.slot[n] = make_item(KIND_END, start_off_next, '0, ERR_OPEN_STR, 8'h00);
          n = n + 2'd1;
        end
        MODE_CHR: begin
          batch.slot[n] = make_item(KIND_END, start_off_next, '0, ERR_OPEN_CHR, 8'h00);
          n = n + 2'd1;
        end
        MODE_IDLE: begin
          batch.slot[n] = make_item(KIND_END, p_inc, '0, ERR_NONE, 8'h00);
          n = n + 2'd1;
        end
        default: ;
      endcase
      mode_next      = MODE_IDLE;
      kw_next        = KW_NONE;
      start_off_next = '0;
      run_next       = '0;
      pos_next       = '0;
    end

    if (n != 2'd0) batch.slot[n - 2'd1].last_result = 1'b1;
    batch.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      kw        <= KW_NONE;
      start_off <= '0;
      run       <= '0;
      pos       <= '0;
    end else if (advance) begin
      mode      <= mode_next;
      kw        <= kw_next;
      start_off <= start_off_next;
      run       <= run_next;
      pos       <= pos_next;
    end
  end

endmodule

`default_nettype wire

/* src/clx_rbuf.sv */
// ----------------------------------------------------------------------------
// clx_rbuf: result buffer
// Holds the results of one item and hands them out one per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module clx_rbuf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire clx_pkg::batch_t     batch,
  input  wire logic                load,
  output logic                     can_load,
  output logic                     token_valid,
  input  wire logic                token_stall,
  output clx_pkg::token_item_t     token_item
);
  import clx_pkg::*;

  token_item_t [2:0] slot;
  logic [1:0]        count;
  logic              take;

  assign token_valid = (count != 2'd0);
  assign token_item  = slot[0];
  assign take        = token_valid && !token_stall;
  // Room for a new batch once the last held result leaves.
  assign can_load    = (count == 2'd0) || (count == 2'd1 && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= batch.count;
    end else if (take) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= batch.slot;
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule

`default_nettype wire

/* src/char_stream_lexer.sv */
// ----------------------------------------------------------------------------
// char_stream_lexer: streaming tokenizer
// Takes source bytes and emits tokens with kind, start offset and length.
// ----------------------------------------------------------------------------
// Usage:
//   The char channel (char_valid / char_stall / char_item) carries one source
//   byte per item plus an end_of_source flag on the last byte. The token
//   channel (token_valid / token_stall / token_item) carries one result per
//   item: a token, the end token, or an error that ends the stream.
//   An item is taken on an edge where valid is high and stall is low.
//   An accepted byte waits in the input register, then is decoded into the
//   result buffer on an edge where the buffer has room.
//   Throughput: one byte per cycle while each byte yields at most one result
//   and the receiver does not stall; a byte yielding more than one result (up
//   to three) holds the input until the buffer is down to its last result,
//   since the result buffer drains one token per cycle while not stalled.
//   Reset (rst, synchronous) empties both registers and puts the lexer
//   between tokens at offset zero. When the receiver stalls, the result
//   buffer holds its tokens and the input register holds one byte, after
//   which char_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module char_stream_lexer #(
  parameter int MAX_TOKEN_LEN    = 4095,
  parameter int SOURCE_ADDR_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 char_valid,
  output logic                      char_stall,
  input  wire clx_pkg::char_item_t  char_item,
  output logic                      token_valid,
  input  wire logic                 token_stall,
  output clx_pkg::token_item_t      token_item
);
  import clx_pkg::*;

  logic        in_full, in_full_next;
  char_item_t  in_item;
  logic        accept;
  logic        advance;
  logic        can_load;
  batch_t      batch;

  // Advance the held byte into the lexer whenever the buffer has room.
  assign advance    = in_full && can_load;
  assign char_stall = in_full && !can_load;
  assign accept     = char_valid && !char_stall;

  always_comb begin
    in_full_next = in_full;
    if (accept) in_full_next = 1'b1;
    else if (advance) in_full_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  // Hold payload while the byte waits; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) in_item <= char_item;
  end

  clx_core #(
    .MAX_TOKEN_LEN    (MAX_TOKEN_LEN),
    .SOURCE_ADDR_BITS (SOURCE_ADDR_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .char_item (in_item),
    .batch     (batch)
  );

  clx_rbuf u_rbuf (
    .clk         (clk),
    .rst         (rst),
    .batch       (batch),
    .load        (advance),
    .can_load    (can_load),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_item  (token_item)
  );

endmodule

`default_nettype wire

/* src/clx_checker.sv */
// ----------------------------------------------------------------------------
// clx_checker: port checks for the character stream lexer
// Watches the token channel and the shape of error results.
// ----------------------------------------------------------------------------
`default_nettype none

module clx_checker (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 token_valid,
  input  wire logic                 token_stall,
  input  wire clx_pkg::token_item_t token_item
);
  import clx_pkg::*;

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid)
    else $error("token valid dropped while stalled");

  a_item_holds: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> $stable(token_item))
    else $error("token item changed while stalled");

  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_item.error_code != ERR_NONE |->
      token_item.tok_kind == KIND_END && token_item.token_length == 12'd0 &&
      token_item.last_result)
    else $error("error result is not a final end token");

  a_bad_char: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_item.error_code != ERR_UNKNOWN |-> token_item.bad_char == 8'h00)
    else $error("bad_char set without unknown-char error");

endmodule

bind char_stream_lexer clx_checker u_clx_checker (
  .clk         (clk),
  .rst         (rst),
  .token_valid (token_valid),
  .token_stall (token_stall),
  .token_item  (token_item)
);

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the character stream lexer
// Feeds sources byte by byte, predicts every token, end marker and error
// in step, and compares each token item that leaves the block field by field.
// ----------------------------------------------------------------------------

module tb;
  import clx_pkg::*;

  localparam int TOKEN_LEN_MAX = 4095;
  localparam int RANDOM_ITEMS  = 220;
  localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

  logic        clk;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  char_item_t  char_item = '0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  token_item_t token_item;

  // Lexer state as the bench sees it, kept at its reset values here.
  mode_t       lex_state = MODE_IDLE;
  kw_t         kw_guess = KW_NONE;
  logic [15:0] tok_start = '0;
  int          run_len = 0;
  logic [15:0] src_pos = '0;

  token_item_t step_tokens[$];
  token_item_t pending_tokens[$];
  int          mismatches = 0;
  int          live_items = 0;
  int          burst_left = 0;
  int          stall_span = 0;
  int          stall_style = 0;

  char_stream_lexer u_dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_item   (char_item),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_item  (token_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------------
  function automatic logic alpha_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic blank_byte(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic string keyword_spelling(kw_t k);
    case (k)
      KW_TO:   return "to";
      KW_FROM: return "from";
      KW_IF:   return "if";
      default: return "";
    endcase
  endfunction

  function automatic logic [4:0] keyword_kind(kw_t k);
    case (k)
      KW_TO:   return KIND_TO;
      KW_FROM: return KIND_FROM;
      default: return KIND_IF;
    endcase
  endfunction

  task automatic put_token(input logic [4:0] kind, input logic [15:0] start, input int len,
                           input logic [2:0] err, input logic [7:0] bad);
    token_item_t t;
    t.tok_kind     = kind;
    t.token_start  = start;
    t.token_length = 12'(len);
    t.error_code   = err;
    t.bad_char     = bad;
    t.last_result  = 1'b0;
    if (step_tokens.size() < 3) step_tokens.push_back(t);
  endtask

  // Report an error token and drop input up to the end of the source.
  task automatic abort_lex(input logic [2:0] err, input logic [15:0] start,
                           input logic [7:0] bad);
    put_token(KIND_END, start, 0, err, bad);
    lex_state = MODE_SKIP;
  endtask

  task automatic lengthen();
    if (run_len >= TOKEN_LEN_MAX) abort_lex(ERR_TOO_LONG, tok_start, 8'h00);
    else run_len++;
  endtask

  task automatic finish_word();
    string spell;
    spell = keyword_spelling(kw_guess);
    if (lex_state == MODE_NUM) begin
      put_token(KIND_NUMBER, tok_start, run_len, ERR_NONE, 8'h00);
    end else if (kw_guess != KW_NONE && run_len == spell.len()) begin
      put_token(keyword_kind(kw_guess), tok_start, run_len, ERR_NONE, 8'h00);
    end else begin
      put_token(KIND_NAME, tok_start, run_len, ERR_NONE, 8'h00);
    end
    lex_state = MODE_IDLE;
  endtask

  // Classify a byte seen between tokens.
  task automatic open_token(input logic [7:0] c, input logic [15:0] p);
    if (blank_byte(c)) return;
    for (int i = 0; i < 12; i++) begin
      if (c == PUNCT_CHARS[i]) begin
        put_token(5'(i), p, 1, ERR_NONE, 8'h00);
        return;
      end
    end
    tok_start = p;
    run_len   = 0;
    kw_guess  = KW_NONE;
    if (c == CH_EQ) begin
      lex_state = MODE_EQ;
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      tok_start = p + 16'd1;
      lex_state = (c == CH_DQUOTE) ? MODE_STR : MODE_CHR;
    end else if (alpha_byte(c)) begin
      run_len   = 1;
      kw_guess  = (c == "t") ? KW_TO : (c == "f") ? KW_FROM : (c == "i") ? KW_IF : KW_NONE;
      lex_state = MODE_NAME;
    end else if (digit_byte(c)) begin
      run_len   = 1;
      lex_state = MODE_NUM;
    end else begin
      abort_lex(ERR_UNKNOWN, p, c);
    end
  endtask

  // Advance the predicted lexer by one byte and queue the tokens it yields.
  task automatic lex_byte(input logic [7:0] c, input logic eos);
    logic [15:0] p;
    logic        again;
    string       spell;
    token_item_t t;
    p = src_pos;
    again = 1'b0;
    step_tokens = {};
    case (lex_state)
      MODE_IDLE: again = 1'b1;
      MODE_EQ: begin
        lex_state = MODE_IDLE;
        if (c == CH_EQ) begin
          put_token(KIND_EE, tok_start, 2, ERR_NONE, 8'h00);
        end else begin
          put_token(KIND_EQ, tok_start, 1, ERR_NONE, 8'h00);
          again = 1'b1;
        end
      end
      MODE_NAME, MODE_NUM: begin
        if (alpha_byte(c) || digit_byte(c) ||
            (lex_state == MODE_NAME ? c == CH_USCORE : c == CH_DOT)) begin
          if (lex_state == MODE_NAME && kw_guess != KW_NONE) begin
            spell = keyword_spelling(kw_guess);
            if (!(run_len < spell.len() && spell[run_len] == c)) kw_guess = KW_NONE;
          end
          lengthen();
        end else begin
          finish_word();
          again = 1'b1;
        end
      end
      MODE_STR, MODE_CHR: begin
        if (c == (lex_state == MODE_STR ? CH_DQUOTE : CH_SQUOTE)) begin
          put_token(lex_state == MODE_STR ? KIND_STR : KIND_CHR, tok_start, run_len,
                    ERR_NONE, 8'h00);
          lex_state = MODE_IDLE;
        end else begin
          lengthen();
        end
      end
      default: ;
    endcase

    if (again) open_token(c, p);

    if (eos) begin
      // Flush what is pending (or mark the end when between tokens), and rearm for the next source.
      case (lex_state)
        MODE_NAME, MODE_NUM: finish_word();
        MODE_EQ:   put_token(KIND_EQ, tok_start, 1, ERR_NONE, 8'h00);
        MODE_STR:  abort_lex(ERR_OPEN_STR, tok_start, 8'h00);
        MODE_CHR:  abort_lex(ERR_OPEN_CHR, tok_start, 8'h00);
        MODE_IDLE: put_token(KIND_END, p + 16'd1, 0, ERR_NONE, 8'h00);
        default: ;
      endcase
      lex_state = MODE_IDLE;
      kw_guess  = KW_NONE;
      tok_start = '0;
      run_len   = 0;
      src_pos   = '0;
    end else begin
      src_pos = p + 16'd1;
    end

    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      t.last_result = (i == step_tokens.size() - 1);
      pending_tokens.push_back(t);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Char channel: bursts of items separated by random gaps
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic eos);
    int         gap;
    char_item_t item;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    item.char_code     = c;
    item.end_of_source = eos;
    char_valid <= 1'b1;
    char_item  <= item;
    do @(posedge clk); while (char_stall);
    if (lex_state != MODE_SKIP) live_items++;
    lex_byte(c, eos);
  endtask

  task automatic send_text(input string s, input logic eos_on_last);
    foreach (s[i]) send_char(s[i], eos_on_last && i == s.len() - 1);
  endtask

  // Random byte for word bodies: 0 letter, 1 name tail, 2 number tail.
  function automatic logic [7:0] word_char(int cls);
    int k;
    k = $urandom_range(0, 9);
    if (cls == 1 && k < 2) return 8'h30 + 8'($urandom_range(0, 9));
    if (cls == 1 && k == 2) return CH_USCORE;
    if (cls == 2 && k < 3) return 8'h30 + 8'($urandom_range(0, 9));
    if (cls == 2 && k == 3) return CH_DOT;
    k = $urandom_range(0, 51);
    return (k < 26) ? 8'h61 + 8'(k) : 8'h41 + 8'(k - 26);
  endfunction

  function automatic logic [7:0] quoted_byte(logic [7:0] quote);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == quote);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Token channel: stall in stretches of none, light and heavy back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span  <= $urandom_range(4, 60);
      stall_style <= $urandom_range(0, 2);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      0:       token_stall <= 1'b0;
      1:       token_stall <= ($urandom_range(0, 3) == 0);
      default: token_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : take_token
    token_item_t want;
    if (!rst && token_valid && !token_stall) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none, got %p", $time, token_item);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("tok_kind", want.tok_kind, token_item.tok_kind);
        check_field("token_start", want.token_start, token_item.token_start);
        check_field("token_length", want.token_length, token_item.token_length);
        check_field("error_code", want.error_code, token_item.error_code);
        check_field("bad_char", want.bad_char, token_item.bad_char);
        check_field("last_result", want.last_result, token_item.last_result);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All twelve single-byte operators, then '=' and "==", with a trailing '='
  // flushed by the end of source.
  task automatic test_punctuation();
    send_text("(){}/,%><*+-", 1'b0);
    send_text("a==b=", 1'b1);
  endtask

  // Keywords and near misses, numbers, strings and chars, every blank byte,
  // and a last byte that yields a name, an operator and the end marker.
  task automatic test_words_and_quotes();
    send_text("if to", 1'b0);
    send_char(8'h09, 1'b0);
    send_text("from", 1'b0);
    send_char(8'h0a, 1'b0);
    send_text("fr_1 tox", 1'b0);
    send_char(8'h0b, 1'b0);
    send_text("9.a", 1'b0);
    send_char(8'h0c, 1'b0);
    send_char(CH_DQUOTE, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(CH_DQUOTE, 1'b0);
    send_char(8'h0d, 1'b0);
    send_char(CH_SQUOTE, 1'b0);
    send_char(CH_SQUOTE, 1'b0);
    send_text(" x(", 1'b1);
  endtask

  // Unknown bytes, open strings and chars; bytes after an error are dropped.
  task automatic test_errors();
    send_text("1 $ab", 1'b0);
    send_text("c", 1'b1);
    send_char(CH_DQUOTE, 1'b0);
    send_text("ab", 1'b1);
    send_text(" ", 1'b0);
    send_char(CH_SQUOTE, 1'b1);
    send_char(8'hff, 1'b1);
    send_char(8'h00, 1'b1);
    send_text(" ", 1'b1);
  endtask

  // Mostly well-formed sources with random content, with some noise bytes
  // and unclosed quotes mixed in.
  task automatic test_random_sources();
    logic [7:0] src[$];
    logic [7:0] quote;
    string      spell;
    int         n;
    while (live_items < RANDOM_ITEMS) begin
      src = {};
      n = $urandom_range(1, 10);
      repeat (n) begin
        if ($urandom_range(0, 3) != 0) begin
          repeat ($urandom_range(1, 2)) src.push_back(BLANKS[$urandom_range(0, 5)]);
        end
        quote = ($urandom_range(0, 1) == 0) ? CH_DQUOTE : CH_SQUOTE;
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: begin
            case ($urandom_range(0, 5))
              0:       src.push_back("t");
              1:       src.push_back("f");
              2:       src.push_back("i");
              default: src.push_back(word_char(0));
            endcase
            repeat ($urandom_range(0, 6)) src.push_back(word_char(1));
          end
          5, 6, 7: begin
            src.push_back(8'h30 + 8'($urandom_range(0, 9)));
            repeat ($urandom_range(0, 5)) src.push_back(word_char(2));
          end
          8, 9, 10, 11: begin
            src.push_back(quote);
            repeat ($urandom_range(0, 6)) src.push_back(quoted_byte(quote));
            src.push_back(quote);
          end
          12, 13, 14: src.push_back(PUNCT_CHARS[$urandom_range(0, 11)]);
          15, 16: begin
            src.push_back(CH_EQ);
            if ($urandom_range(0, 1) == 0) src.push_back(CH_EQ);
          end
          17: src.push_back(8'($urandom_range(0, 255)));
          18: begin
            // Open a quote and never close it.
            src.push_back(quote);
            repeat ($urandom_range(0, 4)) src.push_back(quoted_byte(quote));
          end
          default: begin
            case ($urandom_range(0, 2))
              0:       spell = "to";
              1:       spell = "from";
              default: spell = "if";
            endcase
            if ($urandom_range(0, 3) == 0) spell = spell.substr(0, spell.len() - 2);
            foreach (spell[i]) src.push_back(spell[i]);
            if ($urandom_range(0, 3) == 0) src.push_back(word_char(1));
          end
        endcase
      end
      if ($urandom_range(0, 2) == 0) src.push_back(BLANKS[$urandom_range(0, 5)]);
      foreach (src[i]) send_char(src[i], i == src.size() - 1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_punctuation();
    test_words_and_quotes();
    test_errors();
    test_random_sources();

    // Drain: hold valid low until every predicted token has come out,
    // then watch a while longer for stray tokens.
    char_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
